[rtl/core/rfcb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfcb_pkg
// Shared constants, request and operation codes and the result record of the
// rectangle fill / bounding box canvas core.
// ----------------------------------------------------------------------------
package rfcb_pkg;

  // default canvas geometry
  localparam int CanvasWidthDef  = 128;
  localparam int CanvasHeightDef = 128;

  // depth of the command queue between front and back
  localparam int CmdFifoDepthDef = 2;

  localparam int PixW  = 24;
  localparam int BndW  = 7;
  localparam int ChanW = 8;

  localparam logic [PixW-1:0] PixWhite = 24'hFF_FFFF;

  // request codes on req_type
  localparam logic [1:0] ReqFill = 2'd0;
  localparam logic [1:0] ReqBox  = 2'd1;
  localparam logic [1:0] ReqRead = 2'd2;

  // operation handed from front to back
  typedef enum logic [1:0] {
    OpNop  = 2'd0,
    OpFill = 2'd1,
    OpScan = 2'd2,
    OpRead = 2'd3
  } op_e;

  typedef struct packed {
    logic [BndW-1:0]  first_col;
    logic [BndW-1:0]  last_col;
    logic [BndW-1:0]  first_row;
    logic [BndW-1:0]  last_row;
    logic             canvas_blank;
    logic [ChanW-1:0] pix_red;
    logic [ChanW-1:0] pix_green;
    logic [ChanW-1:0] pix_blue;
  } res_t;

endpackage

[rtl/core/rfcb_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfcb_ram
// Single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module rfcb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/rfcb_cmd_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfcb_cmd_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module rfcb_cmd_fifo #(
  parameter type cmd_t = logic,
  parameter int  DEPTH = rfcb_pkg::CmdFifoDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t data_o,
  output logic empty_o
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[rtl/core/rfcb_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfcb_front
// Request intake: clips rectangles to the canvas, range-checks pixel reads,
// works out the start address and registers one classified command.
// ----------------------------------------------------------------------------
module rfcb_front #(
  parameter type cmd_t         = logic,
  parameter int  CANVAS_WIDTH  = rfcb_pkg::CanvasWidthDef,
  parameter int  CANVAS_HEIGHT = rfcb_pkg::CanvasHeightDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       full_o,
  input  logic [1:0] req_type_i,
  input  logic [6:0] pos_x_i,
  input  logic [6:0] pos_y_i,
  input  logic [7:0] rect_width_i,
  input  logic [7:0] rect_height_i,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  input  logic       clearing_i,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o,
  input  logic       cmd_full_i
);

  localparam int XW   = $clog2(CANVAS_WIDTH);
  localparam int YW   = $clog2(CANVAS_HEIGHT);
  localparam int AW   = $clog2(CANVAS_WIDTH * CANVAS_HEIGHT);
  // wide enough for pos + size (9 bits) and for the canvas size itself
  localparam int XE_W = ($clog2(CANVAS_WIDTH + 1) > 9) ? $clog2(CANVAS_WIDTH + 1) : 9;
  localparam int YE_W = ($clog2(CANVAS_HEIGHT + 1) > 9) ? $clog2(CANVAS_HEIGHT + 1) : 9;

  logic [XE_W-1:0] px_e, x_end, x_endc;
  logic [YE_W-1:0] py_e, y_end, y_endc;
  logic            x_in, y_in, x_span, y_span;
  logic            accept;
  cmd_t            cmd_d, cmd_q;
  logic            valid_q, valid_d;

  always_comb begin
    px_e   = XE_W'(pos_x_i);
    py_e   = YE_W'(pos_y_i);
    x_end  = px_e + XE_W'(rect_width_i);
    y_end  = py_e + YE_W'(rect_height_i);
    x_endc = (x_end > XE_W'(CANVAS_WIDTH)) ? XE_W'(CANVAS_WIDTH) : x_end;
    y_endc = (y_end > YE_W'(CANVAS_HEIGHT)) ? YE_W'(CANVAS_HEIGHT) : y_end;
    x_in   = px_e < XE_W'(CANVAS_WIDTH);
    y_in   = py_e < YE_W'(CANVAS_HEIGHT);
    x_span = x_in && (rect_width_i != '0);
    y_span = y_in && (rect_height_i != '0);

    cmd_d.x0     = XW'(pos_x_i);
    cmd_d.y0     = YW'(pos_y_i);
    cmd_d.x_last = XW'(x_endc - XE_W'(1));
    cmd_d.y_last = YW'(y_endc - YE_W'(1));
    cmd_d.addr   = AW'(pos_y_i) * AW'(CANVAS_WIDTH) + AW'(pos_x_i);
    cmd_d.rgb    = {red_i, green_i, blue_i};

    case (req_type_i)
      rfcb_pkg::ReqFill: cmd_d.op = (x_span && y_span) ? rfcb_pkg::OpFill : rfcb_pkg::OpNop;
      rfcb_pkg::ReqBox:  cmd_d.op = rfcb_pkg::OpScan;
      rfcb_pkg::ReqRead: cmd_d.op = (x_in && y_in) ? rfcb_pkg::OpRead : rfcb_pkg::OpNop;
      default:           cmd_d.op = rfcb_pkg::OpNop;
    endcase
  end

  assign full_o      = clearing_i || (valid_q && cmd_full_i);
  assign accept      = push_i && !full_o;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (valid_q && !cmd_full_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

[rtl/core/rfcb_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfcb_back
// Command execution: canvas clear after reset, rectangle fill, bounding box
// scan and pixel read over the canvas RAM, plus the result register.
// ----------------------------------------------------------------------------
module rfcb_back #(
  parameter type cmd_t         = logic,
  parameter int  CANVAS_WIDTH  = rfcb_pkg::CanvasWidthDef,
  parameter int  CANVAS_HEIGHT = rfcb_pkg::CanvasHeightDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_empty_i,
  input  cmd_t            cmd_i,
  output logic            cmd_pop_o,
  output logic            clearing_o,
  output logic            res_valid_o,
  output rfcb_pkg::res_t  res_o,
  input  logic            res_pop_i
);

  localparam int XW    = $clog2(CANVAS_WIDTH);
  localparam int YW    = $clog2(CANVAS_HEIGHT);
  localparam int Depth = CANVAS_WIDTH * CANVAS_HEIGHT;
  localparam int AW    = $clog2(Depth);

  typedef enum logic [6:0] {
    StClear   = 7'b000_0001,
    StIdle    = 7'b000_0010,
    StFill    = 7'b000_0100,
    StScan    = 7'b000_1000,
    StScanEnd = 7'b001_0000,
    StRead    = 7'b010_0000,
    StDone    = 7'b100_0000
  } state_e;

  state_e          state_q, state_d;
  cmd_t            cmd_q;
  logic [AW-1:0]   addr_q, addr_d, row_addr_q, row_addr_d;
  logic [XW-1:0]   cx_q, cx_d;
  logic [YW-1:0]   cy_q, cy_d;
  // scan data pipeline, aligned with the registered RAM read
  logic            pv_q, pv_d;
  logic [XW-1:0]   px_q;
  logic [YW-1:0]   py_q;
  logic            found_q, found_d;
  logic [XW-1:0]   cmin_q, cmin_d, cmax_q, cmax_d;
  logic [YW-1:0]   rmin_q, rmin_d, rmax_q, rmax_d;
  logic            ram_en, ram_we;
  logic [rfcb_pkg::PixW-1:0] ram_wdata, ram_rdata;
  logic            take_cmd, res_load;
  logic            out_valid_q, out_valid_d;
  rfcb_pkg::res_t  res_d, res_q;
  logic            x_end, y_end;

  rfcb_ram #(
    .WIDTH (rfcb_pkg::PixW),
    .DEPTH (Depth)
  ) u_canvas (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (addr_q),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign clearing_o  = (state_q == StClear);
  assign ram_we      = (state_q == StClear) || (state_q == StFill);
  assign ram_en      = ram_we || (state_q == StScan) || (state_q == StRead);
  assign ram_wdata   = (state_q == StClear) ? rfcb_pkg::PixWhite : cmd_q.rgb;
  assign take_cmd    = (state_q == StIdle) && !cmd_empty_i;
  assign cmd_pop_o   = take_cmd;
  assign res_load    = (state_q == StDone) && (!out_valid_q || res_pop_i);
  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

  // result of the finished command
  always_comb begin
    res_d = '0;
    case (cmd_q.op)
      rfcb_pkg::OpScan: begin
        res_d.first_col    = rfcb_pkg::BndW'(cmin_q);
        res_d.last_col     = rfcb_pkg::BndW'(cmax_q);
        res_d.first_row    = rfcb_pkg::BndW'(rmin_q);
        res_d.last_row     = rfcb_pkg::BndW'(rmax_q);
        res_d.canvas_blank = !found_q;
      end
      rfcb_pkg::OpRead: begin
        {res_d.pix_red, res_d.pix_green, res_d.pix_blue} = ram_rdata;
      end
      default: res_d = '0;
    endcase
  end

  // bounding box accumulation; rows arrive in order, so the last hit row is rmax
  always_comb begin
    found_d = found_q;
    cmin_d  = cmin_q;
    cmax_d  = cmax_q;
    rmin_d  = rmin_q;
    rmax_d  = rmax_q;
    if (take_cmd) begin
      found_d = 1'b0;
      cmin_d  = '0;
      cmax_d  = '0;
      rmin_d  = '0;
      rmax_d  = '0;
    end else if (pv_q && (ram_rdata != rfcb_pkg::PixWhite)) begin
      found_d = 1'b1;
      rmax_d  = py_q;
      if (!found_q) begin
        cmin_d = px_q;
        cmax_d = px_q;
        rmin_d = py_q;
      end else begin
        if (px_q < cmin_q) cmin_d = px_q;
        if (px_q > cmax_q) cmax_d = px_q;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    addr_d     = addr_q;
    row_addr_d = row_addr_q;
    cx_d       = cx_q;
    cy_d       = cy_q;
    pv_d       = 1'b0;
    x_end      = 1'b0;
    y_end      = 1'b0;
    case (state_q)
      StClear: begin
        addr_d = addr_q + 1'b1;
        if (addr_q == AW'(Depth - 1)) begin
          addr_d  = '0;
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (take_cmd) begin
          addr_d     = cmd_i.addr;
          row_addr_d = cmd_i.addr;
          cx_d       = cmd_i.x0;
          cy_d       = cmd_i.y0;
          case (cmd_i.op)
            rfcb_pkg::OpFill: state_d = StFill;
            rfcb_pkg::OpScan: begin
              addr_d  = '0;
              cx_d    = '0;
              cy_d    = '0;
              state_d = StScan;
            end
            rfcb_pkg::OpRead: state_d = StRead;
            default:          state_d = StDone;
          endcase
        end
      end
      StFill: begin
        x_end = (cx_q == cmd_q.x_last);
        y_end = (cy_q == cmd_q.y_last);
        if (!x_end) begin
          cx_d   = cx_q + 1'b1;
          addr_d = addr_q + 1'b1;
        end else if (!y_end) begin
          cx_d       = cmd_q.x0;
          cy_d       = cy_q + 1'b1;
          row_addr_d = row_addr_q + AW'(CANVAS_WIDTH);
          addr_d     = row_addr_q + AW'(CANVAS_WIDTH);
        end else begin
          state_d = StDone;
        end
      end
      StScan: begin
        pv_d   = 1'b1;
        x_end  = (cx_q == XW'(CANVAS_WIDTH - 1));
        y_end  = (cy_q == YW'(CANVAS_HEIGHT - 1));
        addr_d = addr_q + 1'b1;
        if (!x_end) begin
          cx_d = cx_q + 1'b1;
        end else begin
          cx_d = '0;
          cy_d = cy_q + 1'b1;
          if (y_end) begin
            state_d = StScanEnd;
          end
        end
      end
      StScanEnd: state_d = StDone;
      StRead:    state_d = StDone;
      StDone: begin
        if (res_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (res_pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      addr_q      <= '0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      pv_q        <= pv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_addr_q <= row_addr_d;
    cx_q       <= cx_d;
    cy_q       <= cy_d;
    px_q       <= cx_q;
    py_q       <= cy_q;
    found_q    <= found_d;
    cmin_q     <= cmin_d;
    cmax_q     <= cmax_d;
    rmin_q     <= rmin_d;
    rmax_q     <= rmax_d;
    if (take_cmd) begin
      cmd_q <= cmd_i;
    end
    if (res_load) begin
      res_q <= res_d;
    end
  end

endmodule

[rtl/core/rect_fill_canvas_bbox_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_fill_canvas_bbox_core
// RGB canvas, white after reset, with rectangle fill, bounding box query and
// pixel read; one result per request.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  --------  ---------  ---------------------  --------------------------------
//  request   in         push / full            req_type, pos_x/y, rect_width/
//                                              height, red, green, blue
//  result    out        empty / pop            first/last_col, first/last_row,
//                                              canvas_blank, pix_red/green/blue
//
//  After reset the canvas RAM is swept to white, one pixel a cycle, with
//  full held high. Fill writes each clipped pixel in turn, a box query reads
//  every pixel of the canvas, a pixel read reads one pixel, anything else
//  none; each also passes intake and a result load. All of this goes through
//  the single RAM port.
//  Front end and back end are split by a short command queue, so requests are
//  taken while the back end is busy and while a result waits to be popped.
// ----------------------------------------------------------------------------
module rect_fill_canvas_bbox_core #(
  parameter int CANVAS_WIDTH   = rfcb_pkg::CanvasWidthDef,
  parameter int CANVAS_HEIGHT  = rfcb_pkg::CanvasHeightDef,
  parameter int CMD_FIFO_DEPTH = rfcb_pkg::CmdFifoDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // request transfer
  input  logic       push,
  output logic       full,
  input  logic [1:0] req_type_i,
  input  logic [6:0] pos_x_i,
  input  logic [6:0] pos_y_i,
  input  logic [7:0] rect_width_i,
  input  logic [7:0] rect_height_i,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  // result transfer
  output logic       empty,
  input  logic       pop,
  output logic [6:0] first_col_o,
  output logic [6:0] last_col_o,
  output logic [6:0] first_row_o,
  output logic [6:0] last_row_o,
  output logic       canvas_blank_o,
  output logic [7:0] pix_red_o,
  output logic [7:0] pix_green_o,
  output logic [7:0] pix_blue_o
);

  localparam int XW = $clog2(CANVAS_WIDTH);
  localparam int YW = $clog2(CANVAS_HEIGHT);
  localparam int AW = $clog2(CANVAS_WIDTH * CANVAS_HEIGHT);

  // classified command: clipped rectangle corners, start address and colour
  typedef struct packed {
    rfcb_pkg::op_e             op;
    logic [XW-1:0]             x0;
    logic [YW-1:0]             y0;
    logic [XW-1:0]             x_last;
    logic [YW-1:0]             y_last;
    logic [AW-1:0]             addr;
    logic [rfcb_pkg::PixW-1:0] rgb;
  } cmd_t;

  cmd_t           front_cmd, fifo_cmd;
  logic           front_valid, fifo_full, fifo_empty, fifo_pop;
  logic           clearing;
  logic           res_valid;
  rfcb_pkg::res_t res;

  rfcb_front #(
    .cmd_t         (cmd_t),
    .CANVAS_WIDTH  (CANVAS_WIDTH),
    .CANVAS_HEIGHT (CANVAS_HEIGHT)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .req_type_i    (req_type_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .clearing_i    (clearing),
    .cmd_valid_o   (front_valid),
    .cmd_o         (front_cmd),
    .cmd_full_i    (fifo_full)
  );

  rfcb_cmd_fifo #(
    .cmd_t (cmd_t),
    .DEPTH (CMD_FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_cmd),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .data_o  (fifo_cmd),
    .empty_o (fifo_empty)
  );

  rfcb_back #(
    .cmd_t         (cmd_t),
    .CANVAS_WIDTH  (CANVAS_WIDTH),
    .CANVAS_HEIGHT (CANVAS_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (fifo_empty),
    .cmd_i       (fifo_cmd),
    .cmd_pop_o   (fifo_pop),
    .clearing_o  (clearing),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_pop_i   (pop)
  );

  assign empty          = !res_valid;
  assign first_col_o    = res.first_col;
  assign last_col_o     = res.last_col;
  assign first_row_o    = res.first_row;
  assign last_row_o     = res.last_row;
  assign canvas_blank_o = res.canvas_blank;
  assign pix_red_o      = res.pix_red;
  assign pix_green_o    = res.pix_green;
  assign pix_blue_o     = res.pix_blue;

endmodule
